@@ rtl/fpts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpts_pkg: shared types and constants of the task scheduler
// Table geometry, task status codes, item kinds and sequencer states.
// ----------------------------------------------------------------------------
package fpts_pkg;

  // Table geometry
  localparam int NUM_TASKS   = 8;
  localparam int NUM_MUTEXES = 8;
  localparam int TIME_WIDTH  = 16;

  localparam int TASK_W  = $clog2(NUM_TASKS);
  localparam int CNT_W   = $clog2(NUM_TASKS + 1);
  localparam int MUTEX_W = 3;
  localparam int FREE_W  = 8;
  localparam int DUR_W   = 16;

  localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(NUM_TASKS - 1);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(NUM_TASKS - 1);
  localparam logic [CNT_W-1:0]  END_CNT   = CNT_W'(NUM_TASKS);

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_READY  = 2'd1,
    ST_SLEEP  = 2'd2,
    ST_MUTEX  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_TICK   = 2'd0,
    K_SLEEP  = 2'd1,
    K_WAIT   = 2'd2,
    K_CREATE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_FINISH
  } state_t;

  // One task table entry
  typedef struct packed {
    status_t                 status;
    logic [TIME_WIDTH-1:0]   wake;
    logic [MUTEX_W-1:0]      mutex;
  } task_entry_t;

  // Write request into the task table
  typedef struct packed {
    logic                en;
    logic [TASK_W-1:0]   addr;
    task_entry_t         entry;
  } tbl_wr_t;

endpackage

@@ rtl/fixed_priority_task_scheduler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_priority_task_scheduler_unit: fixed-priority task scheduler
// Keeps per-task status, wake time and mutex id in a table memory and picks
// the lowest-index runnable task after each tick, sleep or mutex wait.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in_     | input     | in_valid/in_stall  | kind, duration, mutex_id,
//           |           |                    | mutex_free
//   out_    | output    | out_valid/out_stall| next_task, switched, system_time
//
// A tick goes straight to the scan; a sleep or mutex wait first writes the
// running task's entry and then scans; a create may write a new slot and
// skips the scan. The scan reads one entry per cycle through the table's
// single read port. Reset clears the table valid bits at once, so no clearing
// pass is needed. The result sits in an output register; a new item is taken
// while it waits, and only loading the next result stalls on out_stall.
// ----------------------------------------------------------------------------
module fixed_priority_task_scheduler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic [fpts_pkg::DUR_W-1:0]        in_duration,
  input  logic [fpts_pkg::MUTEX_W-1:0]      in_mutex_id,
  input  logic [fpts_pkg::FREE_W-1:0]       in_mutex_free,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fpts_pkg::TASK_W-1:0]       out_next_task,
  output logic                              out_switched,
  output logic [fpts_pkg::TIME_WIDTH-1:0]   out_system_time
);
  import fpts_pkg::*;

  state_t                 state_r, state_nxt;
  kind_t                  kind_r;
  logic [DUR_W-1:0]       dur_r;
  logic [MUTEX_W-1:0]     mid_r;
  logic [FREE_W-1:0]      free_r;

  logic [TIME_WIDTH-1:0]  tick_r, tick_nxt;
  logic [TASK_W-1:0]      running_r, running_nxt;
  logic [CNT_W-1:0]       created_r, created_nxt;

  logic [CNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic                   ev_valid_r, ev_valid_nxt;
  logic [TASK_W-1:0]      ev_idx_r, ev_idx_nxt;
  logic                   found_r, found_nxt;
  logic [TASK_W-1:0]      pick_r, pick_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [TASK_W-1:0]      out_task_r;
  logic                   out_sw_r;
  logic [TIME_WIDTH-1:0]  out_time_r;
  logic                   out_load;
  logic [TASK_W-1:0]      next_task;

  logic                   accept;
  tbl_wr_t                tbl_wr;
  logic                   rd_en;
  logic [TASK_W-1:0]      rd_addr;
  task_entry_t            rd_entry;
  status_t                ev_status;
  logic                   released;

  fpts_task_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Mutex of the evaluated entry counts as released only if it exists
  assign released = (32'(rd_entry.mutex) < NUM_MUTEXES) && free_r[rd_entry.mutex];

  // Sequencer: next state, table accesses, pick tracking
  always_comb begin
    state_nxt    = state_r;
    tick_nxt     = tick_r;
    running_nxt  = running_r;
    created_nxt  = created_r;
    scan_idx_nxt = scan_idx_r;
    found_nxt    = found_r;
    pick_nxt     = pick_r;
    tbl_wr       = '0;
    rd_en        = 1'b0;
    rd_addr      = scan_idx_r[TASK_W-1:0];
    ev_status    = rd_entry.status;
    out_load     = 1'b0;
    next_task    = found_r ? pick_r : LAST_TASK;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          scan_idx_nxt = '0;
          found_nxt    = 1'b0;
          if (kind_t'(in_kind) == K_TICK) begin
            tick_nxt  = tick_r + 1'b1;
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_UPDATE;
          end
        end
      end

      S_UPDATE: begin
        // Write the running task's entry, or create a slot if the created count is below LAST_CNT
        case (kind_r)
          K_SLEEP: begin
            tbl_wr.en           = 1'b1;
            tbl_wr.addr         = running_r;
            tbl_wr.entry.status = ST_SLEEP;
            tbl_wr.entry.wake   = tick_r + TIME_WIDTH'(dur_r);
            tbl_wr.entry.mutex  = mid_r;
            state_nxt           = S_SCAN;
          end
          K_WAIT: begin
            tbl_wr.en           = 1'b1;
            tbl_wr.addr         = running_r;
            tbl_wr.entry.status = ST_MUTEX;
            tbl_wr.entry.wake   = tick_r;
            tbl_wr.entry.mutex  = mid_r;
            state_nxt           = S_SCAN;
          end
          default: begin
            if (created_r < LAST_CNT) begin
              tbl_wr.en           = 1'b1;
              tbl_wr.addr         = created_r[TASK_W-1:0];
              tbl_wr.entry.status = ST_READY;
              tbl_wr.entry.wake   = tick_r;
              tbl_wr.entry.mutex  = mid_r;
              created_nxt         = created_r + 1'b1;
            end
            state_nxt = S_FINISH;
          end
        endcase
      end

      S_SCAN: begin
        // Issue one read per cycle
        if (scan_idx_r < END_CNT) begin
          rd_en        = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        // Evaluate the entry read last cycle
        if (ev_valid_r) begin
          if (kind_r == K_TICK && rd_entry.status == ST_SLEEP &&
              rd_entry.wake == tick_r) begin
            ev_status = ST_READY;
          end
          if (!found_r && ev_status == ST_READY) begin
            found_nxt = 1'b1;
            pick_nxt  = ev_idx_r;
          end else if (!found_r && ev_status == ST_MUTEX && released) begin
            ev_status = ST_READY;
            found_nxt = 1'b1;
            pick_nxt  = ev_idx_r;
          end
          if (ev_status != rd_entry.status) begin
            tbl_wr.en           = 1'b1;
            tbl_wr.addr         = ev_idx_r;
            tbl_wr.entry        = rd_entry;
            tbl_wr.entry.status = ev_status;
          end
          if (ev_idx_r == LAST_TASK) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (kind_r == K_CREATE) begin
          next_task = running_r;
        end
        if (!out_valid_r || !out_stall) begin
          out_load    = 1'b1;
          running_nxt = next_task;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ev_valid_nxt = rd_en;
  assign ev_idx_nxt   = rd_addr;

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      running_r   <= LAST_TASK;
      created_r   <= '0;
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      scan_idx_r  <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      running_r   <= running_nxt;
      created_r   <= created_nxt;
      ev_valid_r  <= ev_valid_nxt;
      out_valid_r <= out_valid_nxt;
      scan_idx_r  <= scan_idx_nxt;
      found_r     <= found_nxt;
    end
  end

  // Item capture, scan pipeline and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      dur_r  <= in_duration;
      mid_r  <= in_mutex_id;
      free_r <= in_mutex_free;
    end
    ev_idx_r <= ev_idx_nxt;
    pick_r   <= pick_nxt;
    if (out_load) begin
      out_task_r <= next_task;
      out_sw_r   <= (next_task != running_r);
      out_time_r <= tick_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_task   = out_task_r;
  assign out_switched    = out_sw_r;
  assign out_system_time = out_time_r;

`ifndef ASSERT_OFF
  // An accepted item holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("scheduler took an item without going busy");

  // A new result only appears out of the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result appeared outside the finish step");

  // The shown task is the one now running
  a_result_matches_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_task_r == running_r)
    else $error("result task differs from running task");

  // Table entries are evaluated only during the scan
  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid_r |-> state_r == S_SCAN)
    else $error("table entry evaluated outside the scan");
`endif

endmodule

@@ rtl/fpts_task_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpts_task_table: task table memory
// One write and one registered read per cycle. A valid bit per entry makes
// a never-written entry read back as an unused task after reset.
// ----------------------------------------------------------------------------
module fpts_task_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fpts_pkg::tbl_wr_t             wr,
  input  logic                          rd_en,
  input  logic [fpts_pkg::TASK_W-1:0]   rd_addr,
  output fpts_pkg::task_entry_t         rd_entry
);
  import fpts_pkg::*;

  task_entry_t           mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]  valid_r;
  task_entry_t           rd_data_r;
  logic                  rd_valid_r;

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // Unwritten entries read as unused
  always_comb begin
    rd_entry = rd_data_r;
    if (!rd_valid_r) begin
      rd_entry.status = ST_UNUSED;
    end
  end

endmodule
